>>> hdl/sfpb_pkg.sv
`default_nettype none
package sfpb_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = 5;
   localparam logic [31:0] TTL_RESET = 32'd600000;

   localparam logic [2:0] ST_STORED_FREE = 3'd0;
   localparam logic [2:0] ST_STORED_OVER = 3'd1;
   localparam logic [2:0] ST_DUPLICATE   = 3'd2;
   localparam logic [2:0] ST_POPPED      = 3'd3;
   localparam logic [2:0] ST_EMPTY       = 3'd4;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_POP   = 1'b1;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_APPLY,
      FSM_HOLD
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] stamp;
      logic [63:0] id_high;
      logic [63:0] id_low;
      logic [31:0] handle;
   } entry_type;

   // time a lies before time b, wrap-safe
   function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return diff[31];
   endfunction

endpackage
`default_nettype wire

>>> hdl/sfpb_if.sv
`default_nettype none
interface sfpb_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] now_ms;
   logic [63:0] id_high;
   logic [63:0] id_low;
   logic [31:0] packet_handle;
   modport source (output valid, command, now_ms, id_high, id_low, packet_handle,
                   input ready);
   modport sink   (input valid, command, now_ms, id_high, id_low, packet_handle,
                   output ready);
endinterface

interface sfpb_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] out_id_high;
   logic [63:0] out_id_low;
   logic [31:0] out_handle;
   logic [4:0]  queued_count;
   modport source (output valid, status, out_id_high, out_id_low, out_handle,
                   queued_count, input ready);
   modport sink   (input valid, status, out_id_high, out_id_low, out_handle,
                   queued_count, output ready);
endinterface
`default_nettype wire

>>> hdl/sfpb_cell.sv
`default_nettype none
// One slot of the ring; takes its neighbor's entry on every shift cycle.
module sfpb_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift,
   input  wire sfpb_pkg::entry_type  d,
   output sfpb_pkg::entry_type       q
);

   logic        valid_ff;
   logic [31:0] stamp_ff;
   logic [63:0] idh_ff;
   logic [63:0] idl_ff;
   logic [31:0] hnd_ff;

   // clear occupancy on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= d.valid;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (shift) begin
         stamp_ff <= d.stamp;
         idh_ff   <= d.id_high;
         idl_ff   <= d.id_low;
         hnd_ff   <= d.handle;
      end
   end

   assign q = '{valid: valid_ff, stamp: stamp_ff, id_high: idh_ff,
                id_low: idl_ff, handle: hnd_ff};

endmodule
`default_nettype wire

>>> hdl/store_forward_packet_buffer_unit.sv
`default_nettype none
// Packet buffer of sfpb_pkg::ENTRIES slots held in a ring of cells that rotates one
// slot per cycle past a head cell while a command is processed. A command takes two
// full turns of the ring: the first expires aged slots, checks a store for a
// duplicate id and finds the free slot or the oldest one (for a pop, the oldest
// live entry); the second writes or frees the chosen slot and counts occupancy.
// The result is then written to the output register, later only while the previous
// result still waits there. A new command is accepted only once the block is idle
// again, so commands do not overlap. The user must write the TTL register through
// csr_write_enable / csr_write_data only while the block is idle (not enforced).
module store_forward_packet_buffer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   sfpb_req_if.sink         req_if,
   sfpb_rsp_if.source       rsp_if
);

   localparam int E = sfpb_pkg::ENTRIES;
   localparam logic [sfpb_pkg::IDX_W-1:0] LAST = sfpb_pkg::IDX_W'(E - 1);

   sfpb_pkg::state_type state_ff, state_in;
   sfpb_pkg::entry_type cell_q [E];
   sfpb_pkg::entry_type cell_d [E];
   sfpb_pkg::entry_type head_wb;
   logic shift;

   logic [31:0] ttl_ff;
   logic        cmd_ff;
   logic [31:0] now_ff;
   logic [63:0] idh_ff, idl_ff;
   logic [31:0] hnd_ff;
   logic [sfpb_pkg::IDX_W-1:0] cnt_ff, cnt_in;
   logic        dup_ff, dup_in, free_ff, free_in, have_ff, have_in;
   logic [sfpb_pkg::IDX_W-1:0] tgt_ff, tgt_in, old_ff, old_in;
   logic [31:0] otime_ff, otime_in;
   logic [63:0] oh_ff, oh_in, ol_ff, ol_in;
   logic [31:0] ohd_ff, ohd_in;
   logic [sfpb_pkg::CNT_W-1:0] count_ff, count_in;
   logic        rvalid_ff, rvalid_in;
   logic [2:0]  rstat_ff, rstat_in;
   logic [63:0] roh_ff, roh_in, rol_ff, rol_in;
   logic [31:0] rohd_ff, rohd_in;
   logic [4:0]  rcnt_ff, rcnt_in;

   logic        live;
   logic [31:0] age;
   logic [sfpb_pkg::IDX_W-1:0] fin_tgt;
   logic        accept;

   // ring of slot cells
   for (genvar i = 0; i < E; i++) begin : g_cell
      if (i == E - 1) begin : g_tail
         assign cell_d[i] = head_wb;
      end else begin : g_mid
         assign cell_d[i] = cell_q[i + 1];
      end
      sfpb_cell u_cell (.clock(clock), .reset(reset), .shift(shift),
                        .d(cell_d[i]), .q(cell_q[i]));
   end

   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == sfpb_pkg::FSM_IDLE);
   assign shift = (state_ff == sfpb_pkg::FSM_SCAN) || (state_ff == sfpb_pkg::FSM_APPLY);
   assign age = now_ff - cell_q[0].stamp;
   assign live = cell_q[0].valid && (age < ttl_ff);
   assign fin_tgt = free_ff ? tgt_ff : old_ff;

   // hold the TTL register
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= sfpb_pkg::TTL_RESET;
      end else if (csr_write_enable) begin
         ttl_ff <= csr_write_data;
      end
   end

   // latch the command
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_if.command;
         now_ff <= req_if.now_ms;
         idh_ff <= req_if.id_high;
         idl_ff <= req_if.id_low;
         hnd_ff <= req_if.packet_handle;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sfpb_pkg::FSM_IDLE;
         rvalid_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         cnt_ff    <= cnt_in;
      end
   end

   // scan and result registers
   always_ff @(posedge clock) begin
      dup_ff   <= dup_in;
      free_ff  <= free_in;
      have_ff  <= have_in;
      tgt_ff   <= tgt_in;
      old_ff   <= old_in;
      otime_ff <= otime_in;
      oh_ff    <= oh_in;
      ol_ff    <= ol_in;
      ohd_ff   <= ohd_in;
      count_ff <= count_in;
      rstat_ff <= rstat_in;
      roh_ff   <= roh_in;
      rol_ff   <= rol_in;
      rohd_ff  <= rohd_in;
      rcnt_ff  <= rcnt_in;
   end

   // sequence the two turns of the ring
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dup_in   = dup_ff;
      free_in  = free_ff;
      have_in  = have_ff;
      tgt_in   = tgt_ff;
      old_in   = old_ff;
      otime_in = otime_ff;
      oh_in    = oh_ff;
      ol_in    = ol_ff;
      ohd_in   = ohd_ff;
      count_in = count_ff;
      rstat_in = rstat_ff;
      roh_in   = roh_ff;
      rol_in   = rol_ff;
      rohd_in  = rohd_ff;
      rcnt_in  = rcnt_ff;
      rvalid_in = rvalid_ff && !rsp_if.ready;
      head_wb  = cell_q[0];
      unique case (state_ff)
         sfpb_pkg::FSM_IDLE: begin
            if (accept) begin
               state_in = sfpb_pkg::FSM_SCAN;
               cnt_in   = '0;
               dup_in   = 1'b0;
               free_in  = 1'b0;
               have_in  = 1'b0;
               count_in = '0;
            end
         end
         sfpb_pkg::FSM_SCAN: begin
            // expire, detect duplicate, pick free or oldest slot
            head_wb.valid = live;
            if (cmd_ff == sfpb_pkg::CMD_STORE) begin
               if (live && cell_q[0].id_high == idh_ff && cell_q[0].id_low == idl_ff) begin
                  dup_in = 1'b1;
               end
               if (!free_ff) begin
                  if (!live) begin
                     free_in = 1'b1;
                     tgt_in  = cnt_ff;
                  end else if (cnt_ff == '0 ||
                               sfpb_pkg::earlier(cell_q[0].stamp, otime_ff)) begin
                     old_in   = cnt_ff;
                     otime_in = cell_q[0].stamp;
                  end
               end
            end else begin
               if (live && (!have_ff || sfpb_pkg::earlier(cell_q[0].stamp, otime_ff))) begin
                  have_in  = 1'b1;
                  old_in   = cnt_ff;
                  otime_in = cell_q[0].stamp;
                  oh_in    = cell_q[0].id_high;
                  ol_in    = cell_q[0].id_low;
                  ohd_in   = cell_q[0].handle;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = sfpb_pkg::FSM_APPLY;
            end
         end
         sfpb_pkg::FSM_APPLY: begin
            // write or free the chosen slot, count occupancy
            if (cmd_ff == sfpb_pkg::CMD_STORE && !dup_ff && cnt_ff == fin_tgt) begin
               head_wb = '{valid: 1'b1, stamp: now_ff, id_high: idh_ff,
                           id_low: idl_ff, handle: hnd_ff};
            end else if (cmd_ff == sfpb_pkg::CMD_POP && have_ff && cnt_ff == old_ff) begin
               head_wb.valid = 1'b0;
            end
            count_in = count_ff + sfpb_pkg::CNT_W'(head_wb.valid);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = sfpb_pkg::FSM_HOLD;
            end
         end
         sfpb_pkg::FSM_HOLD: begin
            // drop result into the output register once it is free
            if (!rvalid_ff || rsp_if.ready) begin
               rvalid_in = 1'b1;
               state_in  = sfpb_pkg::FSM_IDLE;
               rcnt_in   = count_ff;
               roh_in    = '0;
               rol_in    = '0;
               rohd_in   = '0;
               if (cmd_ff == sfpb_pkg::CMD_STORE) begin
                  if (dup_ff) begin
                     rstat_in = sfpb_pkg::ST_DUPLICATE;
                  end else if (free_ff) begin
                     rstat_in = sfpb_pkg::ST_STORED_FREE;
                  end else begin
                     rstat_in = sfpb_pkg::ST_STORED_OVER;
                  end
               end else if (have_ff) begin
                  rstat_in = sfpb_pkg::ST_POPPED;
                  roh_in   = oh_ff;
                  rol_in   = ol_ff;
                  rohd_in  = ohd_ff;
               end else begin
                  rstat_in = sfpb_pkg::ST_EMPTY;
               end
            end
         end
         default: begin
            state_in = sfpb_pkg::FSM_IDLE;
         end
      endcase
   end

   assign rsp_if.valid        = rvalid_ff;
   assign rsp_if.status       = rstat_ff;
   assign rsp_if.out_id_high  = roh_ff;
   assign rsp_if.out_id_low   = rol_ff;
   assign rsp_if.out_handle   = rohd_ff;
   assign rsp_if.queued_count = rcnt_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == sfpb_pkg::FSM_SCAN)
      else $error("command accepted without starting scan");

   a_pop_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != sfpb_pkg::ST_POPPED) |->
      (rsp_if.out_id_high == '0 && rsp_if.out_id_low == '0 && rsp_if.out_handle == '0))
      else $error("nonzero pop fields on non-pop result");

   a_ring_aligned_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sfpb_pkg::FSM_IDLE) |-> cnt_ff == '0)
      else $error("ring out of alignment while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && E < 32) |-> 32'(rsp_if.queued_count) <= 32'(E))
      else $error("occupancy count exceeds slot count");

endmodule
`default_nettype wire
